// ----- rtl/core/utv_pkg.sv -----
// shared types, codes and constants for the utf-16 text field validator
package utv_pkg;

    // field widths
    localparam int UNIT_W   = 16;
    localparam int LIMIT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int TCOUNT_W = 9;
    localparam int CFG_IDX_W = 1;

    // default counter width, counters saturate at 2^COUNT_BITS - 1
    localparam int COUNT_BITS_DEF = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AUTHOR_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LIMIT = 1'd1;

    // limit values after reset
    localparam logic [LIMIT_W-1:0] AUTHOR_LIMIT_RST  = 9'd32;
    localparam logic [LIMIT_W-1:0] MESSAGE_LIMIT_RST = 9'd256;

    // text modes
    localparam logic MODE_AUTHOR  = 1'b0;
    localparam logic MODE_MESSAGE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_VALID       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_AUTHOR  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_MESSAGE = 2'd2;

    // code unit ranges
    localparam logic [UNIT_W-1:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [UNIT_W-1:0] C0_CTRL_HI   = 16'h001F;
    localparam logic [UNIT_W-1:0] C1_CTRL_LO   = 16'h007F;
    localparam logic [UNIT_W-1:0] C1_CTRL_HI   = 16'h009F;
    localparam logic [UNIT_W-1:0] COLON_UNIT   = 16'h003A;

    // code unit classes handed from front to back
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SPACE,
        CLS_COLON,
        CLS_CTRL,
        CLS_HIGH,
        CLS_LOW
    } t_unit_class;

    // input transaction
    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              mode;
        logic              last;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TCOUNT_W-1:0] trimmed_count;
    } t_out_item;

    // classified unit held in the queue
    typedef struct packed {
        t_unit_class cls;
        logic        mode;
        logic        last;
    } t_cls_item;

    // unicode whitespace test on one code unit
    function automatic logic is_space_unit(input logic [UNIT_W-1:0] u);
        return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 ||
            u == 16'h0085 || u == 16'h00A0 || u == 16'h1680 ||
            (u >= 16'h2000 && u <= 16'h200A) || u == 16'h2028 ||
            u == 16'h2029 || u == 16'h202F || u == 16'h205F || u == 16'h3000;
    endfunction

endpackage

// ----- rtl/core/utv_front.sv -----
// front end: classifies each incoming code unit for the back end
module utv_front (
    input  utv_pkg::t_in_item  i_item,
    output utv_pkg::t_cls_item o_entry
);
    import utv_pkg::*;

    logic        high_surr;
    logic        low_surr;
    logic        ctrl;
    t_unit_class cls;

    // range decodes
    assign high_surr = (i_item.code_unit >= HIGH_SURR_LO) && (i_item.code_unit <= HIGH_SURR_HI);
    assign low_surr  = (i_item.code_unit >= LOW_SURR_LO) && (i_item.code_unit <= LOW_SURR_HI);
    assign ctrl      = (i_item.code_unit <= C0_CTRL_HI) ||
                       ((i_item.code_unit >= C1_CTRL_LO) && (i_item.code_unit <= C1_CTRL_HI));

    // priority: surrogates, control (wins over whitespace), colon, whitespace
    always_comb begin
        if (high_surr) begin
            cls = CLS_HIGH;
        end else if (low_surr) begin
            cls = CLS_LOW;
        end else if (ctrl) begin
            cls = CLS_CTRL;
        end else if (i_item.code_unit == COLON_UNIT) begin
            cls = CLS_COLON;
        end else if (is_space_unit(i_item.code_unit)) begin
            cls = CLS_SPACE;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign o_entry.cls  = cls;
    assign o_entry.mode = i_item.mode;
    assign o_entry.last = i_item.last;

endmodule

// ----- rtl/core/utv_queue.sv -----
// two-entry queue between front and back ends
module utv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  utv_pkg::t_cls_item i_push_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_not_empty,
    output utv_pkg::t_cls_item o_pop_data
);
    import utv_pkg::*;

    t_cls_item   r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_full      = (r_count == 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_pop_data  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- rtl/core/utv_back.sv -----
// back end: per-string state, trimming, counting and the result register
module utv_back #(
    parameter int COUNT_BITS = utv_pkg::COUNT_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_entry_valid,
    input  utv_pkg::t_cls_item           i_entry,
    output logic                         o_pop,
    input  logic [utv_pkg::LIMIT_W-1:0]  i_author_limit,
    input  logic [utv_pkg::LIMIT_W-1:0]  i_message_limit,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output utv_pkg::t_out_item           o_out_data
);
    import utv_pkg::*;

    localparam logic [COUNT_BITS-1:0] CAP = {COUNT_BITS{1'b1}};
    localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

    // string state
    logic                  r_in_string;
    logic                  r_mode;
    logic                  r_err;
    logic                  r_hs;
    logic                  r_cs;
    logic [COUNT_BITS-1:0] r_sc;
    logic [COUNT_BITS-1:0] r_pc;

    logic                  n_mode;
    logic                  n_err;
    logic                  n_hs;
    logic                  n_cs;
    logic [COUNT_BITS-1:0] n_sc;
    logic [COUNT_BITS-1:0] n_pc;

    logic                  cur_cs;
    logic [COUNT_BITS-1:0] cur_sc;
    logic [COUNT_BITS-1:0] cur_pc;
    logic [COUNT_BITS:0]   pc_inc;
    logic [COUNT_BITS-1:0] pc_sat;
    logic [COUNT_BITS:0]   sc_sum;
    logic [COUNT_BITS-1:0] sc_take;
    logic                  take;

    logic                  r_out_valid;
    t_out_item             r_out_data;
    logic                  slot_free;
    logic [LIMIT_W-1:0]    limit;
    logic [CMP_W-1:0]      cnt_ext;
    logic                  bad;

    // the output slot frees up when empty or being taken
    assign slot_free = !r_out_valid || i_out_ready;
    assign o_pop     = i_entry_valid && (!i_entry.last || slot_free);

    // state seen by this unit: a new string starts from cleared state
    assign n_mode = r_in_string ? r_mode : i_entry.mode;
    assign cur_cs = r_in_string && r_cs;
    assign cur_sc = r_in_string ? r_sc : '0;
    assign cur_pc = r_in_string ? r_pc : '0;

    // saturating pending + 1, then saturating add into the scalar count
    assign pc_inc  = {1'b0, cur_pc} + {{COUNT_BITS{1'b0}}, 1'b1};
    assign pc_sat  = pc_inc[COUNT_BITS] ? CAP : pc_inc[COUNT_BITS-1:0];
    assign sc_sum  = {1'b0, cur_sc} + {1'b0, pc_sat};
    assign sc_take = sc_sum[COUNT_BITS] ? CAP : sc_sum[COUNT_BITS-1:0];

    // unit decision
    always_comb begin
        n_err = r_in_string && r_err;
        n_hs  = 1'b0;
        take  = 1'b0;
        n_pc  = cur_pc;
        if (r_in_string && r_hs) begin
            // unit after a high surrogate must be its low half
            if (i_entry.cls == CLS_LOW) begin
                take = 1'b1;
            end else begin
                n_err = 1'b1;
            end
        end else begin
            unique case (i_entry.cls)
                CLS_HIGH:  n_hs = 1'b1;
                CLS_LOW:   n_err = 1'b1;
                CLS_CTRL:  n_err = 1'b1;
                CLS_COLON: begin
                    if (n_mode == MODE_AUTHOR) begin
                        n_err = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
                CLS_SPACE: begin
                    if (cur_cs) begin
                        n_pc = pc_sat;
                    end
                end
                CLS_OTHER: take = 1'b1;
                default:   n_err = 1'b1;
            endcase
        end
        if (take) begin
            n_pc = '0;
        end
    end

    assign n_cs = cur_cs || take;
    assign n_sc = take ? sc_take : cur_sc;

    // verdict on the last unit
    assign limit   = (n_mode == MODE_MESSAGE) ? i_message_limit : i_author_limit;
    assign cnt_ext = CMP_W'(n_sc);
    assign bad     = n_err || n_hs || !n_cs || (cnt_ext > CMP_W'(limit));

    // string state update, cleared after the last unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_string <= 1'b0;
            r_mode      <= MODE_AUTHOR;
            r_err       <= 1'b0;
            r_hs        <= 1'b0;
            r_cs        <= 1'b0;
            r_sc        <= '0;
            r_pc        <= '0;
        end else if (o_pop) begin
            r_in_string <= !i_entry.last;
            r_mode      <= i_entry.last ? MODE_AUTHOR : n_mode;
            r_err       <= !i_entry.last && n_err;
            r_hs        <= !i_entry.last && n_hs;
            r_cs        <= !i_entry.last && n_cs;
            r_sc        <= i_entry.last ? '0 : n_sc;
            r_pc        <= i_entry.last ? '0 : n_pc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_entry.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_out_data.status        <= !bad ? STATUS_VALID :
                                        (n_mode == MODE_MESSAGE) ? STATUS_BAD_MESSAGE
                                                                 : STATUS_BAD_AUTHOR;
            r_out_data.trimmed_count <= cnt_ext[TCOUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/utf16_text_field_validator.sv -----
// top level of the utf-16 text field validator
// The block takes one UTF-16 code unit per cycle while the queue has room and returns
// one result per string, on the unit marked last: status valid, invalid author or
// invalid message, and the scalar count of the whitespace-trimmed text. The front end
// classifies each unit in the cycle it is accepted and writes it into a two-entry
// queue; the back end takes one queued unit per cycle, unless a last unit waits for the
// output register, and updates the string state, so the sustained rate is one unit per
// clock while no result is held. A last unit goes through the queue into the back end,
// which then loads the result register; the result waits there until it is taken.
// While that register is held the back end keeps consuming units that are not last, and
// input stalls only once the queue is full. Limits are written through the configuration
// channel, which is always ready; there is no start-up pass after reset.
module utf16_text_field_validator #(
    parameter int COUNT_BITS = utv_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  utv_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output utv_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [utv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [utv_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import utv_pkg::*;

    logic [LIMIT_W-1:0] r_auth_lim;
    logic [LIMIT_W-1:0] r_msg_lim;
    t_cls_item          entry_in;
    t_cls_item          entry_out;
    logic               q_full;
    logic               q_not_empty;
    logic               q_pop;
    logic               in_push;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;
    assign in_push     = i_in_valid && !q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_lim <= AUTHOR_LIMIT_RST;
            r_msg_lim  <= MESSAGE_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_AUTHOR_LIMIT:  r_auth_lim <= i_cfg_data;
                CFG_MESSAGE_LIMIT: r_msg_lim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    utv_front u_front (
        .i_item  (i_in_data),
        .o_entry (entry_in)
    );

    utv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_push),
        .i_push_data (entry_in),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_pop_data  (entry_out)
    );

    utv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry_valid   (q_not_empty),
        .i_entry         (entry_out),
        .o_pop           (q_pop),
        .i_author_limit  (r_auth_lim),
        .i_message_limit (r_msg_lim),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_data      (o_out_data)
    );

endmodule

// ----- rtl/core/utv_checker.sv -----
// port-level checker for the utf-16 text field validator, with its bind
module utv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input utv_pkg::t_out_item o_out_data
);
    import utv_pkg::*;

    // a waiting result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // leaving reset: no result pending and the queue has room
    a_reset_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("block not clean after reset");

    // a valid string always has trimmed content
    a_valid_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_VALID |-> o_out_data.trimmed_count != '0)
        else $error("valid status with empty trimmed text");

    // with the result taken and input stalled, input room must reopen next cycle
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready && !o_out_valid |=> o_in_ready)
        else $error("queue stayed full with the output slot free");

endmodule

bind utf16_text_field_validator utv_checker u_utv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- sim/utf16_text_field_validator_tb.sv -----
// self-checking testbench for the utf-16 text field validator, random strings against a predictor
`timescale 1ns / 100ps

module utf16_text_field_validator_tb;
    import utv_pkg::*;

    localparam int COUNT_CAP = (1 << COUNT_BITS_DEF) - 1;
    localparam int PHASE_UNITS = 130;

    // tracks string state and the verdicts still owed by the block
    class field_checker;
        logic [LIMIT_W-1:0]  author_lim;
        logic [LIMIT_W-1:0]  message_lim;
        bit                  in_str;
        logic                str_mode;
        bit                  err;
        bit                  high_wait;
        bit                  has_content;
        logic [TCOUNT_W-1:0] scalars;
        logic [TCOUNT_W-1:0] held_blanks;
        t_out_item           expected_verdicts[$];
        int                  errors;

        function new();
            author_lim  = AUTHOR_LIMIT_RST;
            message_lim = MESSAGE_LIMIT_RST;
            errors      = 0;
            clear_text();
        endfunction

        function void clear_text();
            in_str      = 0;
            str_mode    = MODE_AUTHOR;
            err         = 0;
            high_wait   = 0;
            has_content = 0;
            scalars     = '0;
            held_blanks = '0;
        endfunction

        function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] val);
            if (idx == CFG_AUTHOR_LIMIT) author_lim = val;
            else message_lim = val;
        endfunction

        function logic [TCOUNT_W-1:0] sat_sum(logic [TCOUNT_W-1:0] a, logic [TCOUNT_W-1:0] b);
            int s;
            s = int'(a) + int'(b);
            return (s > COUNT_CAP) ? TCOUNT_W'(COUNT_CAP) : TCOUNT_W'(s);
        endfunction

        // unicode whitespace, control ones included
        function bit is_blank(logic [UNIT_W-1:0] u);
            case (u)
                16'h0020, 16'h0085, 16'h00A0, 16'h1680, 16'h2028,
                16'h2029, 16'h202F, 16'h205F, 16'h3000: return 1;
                default: return (u >= 16'h0009 && u <= 16'h000D) ||
                    (u >= 16'h2000 && u <= 16'h200A);
            endcase
        endfunction

        // held whitespace becomes part of the text once content follows
        function void take_content();
            scalars     = sat_sum(scalars, sat_sum(held_blanks, TCOUNT_W'(1)));
            held_blanks = '0;
            has_content = 1;
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        // one accepted code unit, a verdict is owed on the last one
        function void note_unit(t_in_item it);
            logic [UNIT_W-1:0]  u;
            logic [LIMIT_W-1:0] lim;
            t_out_item          v;
            bit                 bad;
            u = it.code_unit;
            if (!in_str) begin
                clear_text();
                in_str   = 1;
                str_mode = it.mode;
            end
            if (high_wait) begin
                high_wait = 0;
                if (u >= LOW_SURR_LO && u <= LOW_SURR_HI) take_content();
                else err = 1;
            end else if (u >= HIGH_SURR_LO && u <= HIGH_SURR_HI) begin
                high_wait = 1;
            end else if (u >= LOW_SURR_LO && u <= LOW_SURR_HI) begin
                err = 1;
            end else if (u <= C0_CTRL_HI || (u >= C1_CTRL_LO && u <= C1_CTRL_HI) ||
                    (str_mode == MODE_AUTHOR && u == COLON_UNIT)) begin
                err = 1;
            end else if (is_blank(u)) begin
                if (has_content) held_blanks = sat_sum(held_blanks, TCOUNT_W'(1));
            end else begin
                take_content();
            end
            if (it.last) begin
                lim = (str_mode == MODE_MESSAGE) ? message_lim : author_lim;
                bad = err || high_wait || !has_content || (scalars > TCOUNT_W'(lim));
                if (!bad) v.status = STATUS_VALID;
                else if (str_mode == MODE_MESSAGE) v.status = STATUS_BAD_MESSAGE;
                else v.status = STATUS_BAD_AUTHOR;
                v.trimmed_count = scalars;
                expected_verdicts.insert(expected_verdicts.size(), v);
                clear_text();
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // compare one accepted result with the oldest verdict
        task check_verdict(t_out_item got);
            t_out_item want;
            if (expected_verdicts.size() == 0) begin
                report($sformatf("unexpected result, status %0d count %0d",
                    got.status, got.trimmed_count));
                return;
            end
            want = expected_verdicts.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.trimmed_count !== want.trimmed_count)
                report($sformatf("trimmed count %0d, wanted %0d",
                    got.trimmed_count, want.trimmed_count));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_AUTHOR_LIMIT;
    logic [LIMIT_W-1:0]    i_cfg_data = '0;

    field_checker          board;
    int                    tx_idle_pct = 9;
    int                    rx_idle_pct = 82;
    int                    rx_hold = 0;
    int                    phase_items = 0;
    logic [LIMIT_W-1:0]    cur_author = AUTHOR_LIMIT_RST;
    logic [LIMIT_W-1:0]    cur_message = MESSAGE_LIMIT_RST;
    logic [UNIT_W-1:0]     text_units[$];

    utf16_text_field_validator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: check accepted transactions, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) board.check_verdict(o_out_data);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // overall run limit
    initial begin
        #2000000;
        $display("utf16_text_field_validator test failed");
        $finish;
    end

    // offer one unit, return at the edge where it is taken
    task automatic send_unit(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_unit(it);
        phase_items++;
    endtask

    // send the built text, mode counts only on the first unit
    task automatic send_text(input logic mode);
        t_in_item it;
        for (int k = 0; k < text_units.size(); k++) begin
            it.code_unit = text_units[k];
            it.mode      = (k == 0) ? mode : 1'($urandom_range(0, 1));
            it.last      = (k == text_units.size() - 1);
            send_unit(it);
        end
    endtask

    // stop offering, let every verdict come back and the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [LIMIT_W-1:0] a_lim,
                                input logic [LIMIT_W-1:0] m_lim);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_AUTHOR_LIMIT;
        i_cfg_data  <= a_lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_limit(CFG_AUTHOR_LIMIT, a_lim);
        i_cfg_index <= CFG_MESSAGE_LIMIT;
        i_cfg_data  <= m_lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_limit(CFG_MESSAGE_LIMIT, m_lim);
        i_cfg_valid <= 1'b0;
        cur_author  = a_lim;
        cur_message = m_lim;
    endtask

    // add one unit at the end of the text being built
    function automatic void append_unit(input logic [UNIT_W-1:0] u);
        text_units.insert(text_units.size(), u);
    endfunction

    function automatic logic [UNIT_W-1:0] pick_letter();
        logic [UNIT_W-1:0] u;
        u = UNIT_W'($urandom_range(16'h0021, 16'h007E));
        if (u == COLON_UNIT) u = 16'h0078;
        return u;
    endfunction

    // whitespace that is not also control
    function automatic logic [UNIT_W-1:0] pick_blank();
        int k;
        k = $urandom_range(0, 16);
        if (k <= 10) return UNIT_W'(16'h2000 + k);
        case (k)
            11: return 16'h0020;
            12: return 16'h00A0;
            13: return 16'h1680;
            14: return 16'h2028;
            15: return 16'h2029;
            default: begin
                k = $urandom_range(0, 2);
                return (k == 0) ? 16'h202F : ((k == 1) ? 16'h205F : 16'h3000);
            end
        endcase
    endfunction

    // printable unit above the control range, never a surrogate
    function automatic logic [UNIT_W-1:0] pick_wide();
        logic [UNIT_W-1:0] u;
        do u = UNIT_W'($urandom_range(16'h00A0, 16'hFFFF));
        while (u >= HIGH_SURR_LO && u <= LOW_SURR_HI);
        return u;
    endfunction

    function automatic void push_clean(input logic mode);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) append_unit(pick_letter());
        else if (r < 55) append_unit(pick_blank());
        else if (r < 72) append_unit(pick_wide());
        else if (r < 85) begin
            append_unit(UNIT_W'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            append_unit(UNIT_W'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)));
        end else if (r < 90) begin
            append_unit((mode == MODE_MESSAGE) ? COLON_UNIT : pick_letter());
        end else begin
            append_unit(pick_wide());
        end
    endfunction

    // units that break a rule, plus raw values
    function automatic void push_noise();
        case ($urandom_range(0, 5))
            0: append_unit(UNIT_W'($urandom_range(0, C0_CTRL_HI)));
            1: append_unit(UNIT_W'($urandom_range(C1_CTRL_LO, C1_CTRL_HI)));
            2: append_unit(COLON_UNIT);
            3: append_unit(UNIT_W'($urandom_range(HIGH_SURR_LO, HIGH_SURR_HI)));
            4: append_unit(UNIT_W'($urandom_range(LOW_SURR_LO, LOW_SURR_HI)));
            default: append_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
        endcase
    endfunction

    function automatic void build_text(input logic mode, input int n, input bit noisy,
                                       input int lead, input int trail);
        text_units.delete();
        repeat (lead) append_unit(pick_blank());
        while (text_units.size() < lead + n) begin
            if (noisy && $urandom_range(0, 99) < 15) push_noise();
            else push_clean(mode);
        end
        repeat (trail) append_unit(pick_blank());
    endfunction

    // one random string, lengths mostly short or close to the limit
    task automatic send_random_string();
        logic               mode;
        logic [LIMIT_W-1:0] lim;
        int                 r;
        int                 n;
        int                 lead;
        int                 trail;
        bit                 noisy;
        mode = 1'($urandom_range(0, 1));
        lim  = (mode == MODE_MESSAGE) ? cur_message : cur_author;
        r    = $urandom_range(0, 99);
        if (r < 55) n = $urandom_range(1, 8);
        else if (r < 80) n = (lim <= 40) ? $urandom_range((lim > 3) ? lim - 3 : 0, lim + 3)
                                         : $urandom_range(1, 20);
        else if (r < 95) n = $urandom_range(9, 40);
        else n = 0;
        noisy = ($urandom_range(0, 99) < 30);
        lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (n == 0 && lead == 0) lead = 1;
        build_text(mode, n, noisy, lead, trail);
        send_text(mode);
    endtask

    // long strings drive the scalar counter into saturation, and with a blank run the pending counter too
    task automatic send_long_string(input logic mode, input bit blank_run);
        text_units.delete();
        if (blank_run) begin
            append_unit(pick_letter());
            repeat (COUNT_CAP + 8) append_unit(pick_blank());
            append_unit(pick_letter());
        end else begin
            repeat (COUNT_CAP + 4) append_unit(pick_letter());
        end
        send_text(mode);
    endtask

    task automatic send_directed();
        text_units = '{16'h0041};
        send_text(MODE_AUTHOR);
        // leading blanks dropped, inner kept, trailing dropped
        text_units = '{16'h0020, 16'h0062, 16'h3000, 16'h0063, 16'h0020};
        send_text(MODE_MESSAGE);
        text_units = '{COLON_UNIT};
        send_text(MODE_AUTHOR);
        text_units = '{COLON_UNIT};
        send_text(MODE_MESSAGE);
        // controls, including whitespace that is also control
        text_units = '{16'h0000};
        send_text(MODE_MESSAGE);
        text_units = '{C1_CTRL_HI};
        send_text(MODE_AUTHOR);
        text_units = '{16'h0009};
        send_text(MODE_MESSAGE);
        text_units = '{16'h0085};
        send_text(MODE_AUTHOR);
        // surrogate pairs at the range ends
        text_units = '{HIGH_SURR_LO, LOW_SURR_LO};
        send_text(MODE_AUTHOR);
        text_units = '{HIGH_SURR_HI, LOW_SURR_HI};
        send_text(MODE_MESSAGE);
        // high surrogate without its low half, then on the last unit, then a lone low half
        text_units = '{HIGH_SURR_LO, 16'h0041};
        send_text(MODE_MESSAGE);
        text_units = '{16'h0041, HIGH_SURR_HI};
        send_text(MODE_AUTHOR);
        text_units = '{LOW_SURR_LO};
        send_text(MODE_MESSAGE);
        // nothing left after trimming, then a plain unit and a control before a letter
        text_units = '{16'h1680};
        send_text(MODE_AUTHOR);
        text_units = '{16'hFFFF};
        send_text(MODE_MESSAGE);
        text_units = '{C1_CTRL_LO, 16'h0041};
        send_text(MODE_AUTHOR);
    endtask

    // phase list: limits, idling profile, extras
    initial begin
        logic [LIMIT_W-1:0] a_lims[6];
        logic [LIMIT_W-1:0] m_lims[6];
        bit                 held;
        board  = new();
        a_lims = '{AUTHOR_LIMIT_RST, 9'd1, 9'd510, 9'd5, 9'd0, 9'd0};
        m_lims = '{MESSAGE_LIMIT_RST, 9'd510, 9'd1, 9'd12, 9'd511, 9'd0};
        a_lims[5] = LIMIT_W'($urandom_range(1, 40));
        m_lims[5] = LIMIT_W'($urandom_range(1, 510));
        held = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                tx_idle_pct = 9;
                rx_idle_pct = 82;
            end else if (p < 4) begin
                tx_idle_pct = 82;
                rx_idle_pct = 9;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p > 0) write_limits(a_lims[p], m_lims[p]);
            phase_items = 0;
            if (p == 0) send_directed();
            if (p == 1) send_long_string(MODE_MESSAGE, 1);
            if (p == 2) send_long_string(MODE_AUTHOR, 0);
            if (p == 4) send_long_string(MODE_MESSAGE, 0);
            while (phase_items < PHASE_UNITS) begin
                send_random_string();
                // long receiver hold-off while strings keep coming
                if (p == 3 && !held && phase_items > 40) begin
                    rx_hold = 300;
                    held = 1;
                end
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("utf16_text_field_validator test passed");
        end else begin
            $display("utf16_text_field_validator test failed");
        end
        $finish;
    end

endmodule
